// ----- design/lspe_pkg.sv -----
// ----------------------------------------------------------------------------
// LED strip pulse encoder package
// Shared widths, register indexes, reset timings and the configuration bundle.
// ----------------------------------------------------------------------------
package lspe_pkg;

    localparam int NS_W      = 16;
    localparam int TICK_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int BYTE_W    = 8;
    localparam int PIX_W     = 4 * BYTE_W;
    localparam int CNT_W     = 5;

    // Items per pixel, minus one, for the two color modes.
    localparam logic [CNT_W-1:0] LAST_IDX_3 = CNT_W'(3 * BYTE_W - 1);
    localparam logic [CNT_W-1:0] LAST_IDX_4 = CNT_W'(4 * BYTE_W - 1);

    // Divide by the 50 ns tick as a multiply by ceil(2^22 / 50) and a shift.
    // The rounding error stays below one step for every 16-bit value.
    localparam int              RECIP_W     = 17;
    localparam int              RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP    = 17'd83887;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_MODE   = 3'd0,
        REG_ZERO_HIGH_NS = 3'd1,
        REG_ZERO_LOW_NS  = 3'd2,
        REG_ONE_HIGH_NS  = 3'd3,
        REG_ONE_LOW_NS   = 3'd4,
        REG_RESET_LOW_NS = 3'd5
    } cfg_index_t;

    // Reset timings already in ticks (400, 850, 800, 450 and 50000 ns).
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 11'd8;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 11'd17;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 11'd16;
    localparam logic [TICK_W-1:0] RST_ONE_LOW   = 11'd9;
    localparam logic [TICK_W-1:0] RST_RESET_LOW = 11'd1000;

    typedef struct packed {
        logic              color_mode;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] reset_low;
    } cfg_ticks_t;

endpackage

// ----- design/lspe_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// LED strip pulse encoder configuration registers
// Takes register writes and keeps the timings converted to 50 ns ticks.
// ----------------------------------------------------------------------------
module lspe_cfg_regs
    import lspe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [NS_W-1:0]      wr_data,
    output cfg_ticks_t           cfg
);

    cfg_ticks_t                 cfg_reg;
    cfg_ticks_t                 cfg_next;
    logic [NS_W+RECIP_W-1:0]    product;
    logic [TICK_W-1:0]          ticks;

    // The quotient never exceeds 1310, so eleven bits hold it.
    assign product = {{RECIP_W{1'b0}}, wr_data} * {{NS_W{1'b0}}, RECIP};
    assign ticks   = product[RECIP_SHIFT +: TICK_W];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_COLOR_MODE:   cfg_next.color_mode = wr_data[0];
                REG_ZERO_HIGH_NS: cfg_next.zero_high  = ticks;
                REG_ZERO_LOW_NS:  cfg_next.zero_low   = ticks;
                REG_ONE_HIGH_NS:  cfg_next.one_high   = ticks;
                REG_ONE_LOW_NS:   cfg_next.one_low    = ticks;
                REG_RESET_LOW_NS: cfg_next.reset_low  = ticks;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_mode <= 1'b0;
            cfg_reg.zero_high  <= RST_ZERO_HIGH;
            cfg_reg.zero_low   <= RST_ZERO_LOW;
            cfg_reg.one_high   <= RST_ONE_HIGH;
            cfg_reg.one_low    <= RST_ONE_LOW;
            cfg_reg.reset_low  <= RST_RESET_LOW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/led_strip_pulse_encoder.sv -----
// ----------------------------------------------------------------------------
// LED strip pulse encoder
// Expands one pixel into one high/low pulse item per data bit.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel arrives on the s_axis channel as four stored bytes, with tlast set
//   on the final pixel of the strip. The block sends byte 1, byte 0, byte 2 and,
//   in four-byte mode, byte 3, each MSB first, as one m_axis transaction per bit.
//   Each item carries the high and low times in 50 ns ticks; tuser marks the
//   last item of a pixel and tlast the last item of the strip, whose low time
//   is the reset gap.
//   Timings are written through the cfg channel in nanoseconds and converted
//   to ticks at the write, so they must be written while the block is idle.
//   The first item of a pixel passes through the pixel register and then the
//   output register. Throughput: one item per cycle while the receiver does
//   not stall, set by the single output port; a pixel is 24 or 32 items.
//   The next pixel is taken in the same cycle the previous one's last item
//   moves into the output register, so pixels follow without gaps.
//   When the receiver stalls, the output register holds its item and the
//   pixel register waits; s_axis_tready drops until the pixel is drained.
//   Reset empties both registers and loads the default timings.
// ----------------------------------------------------------------------------
module led_strip_pulse_encoder
    import lspe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // pixel_byte0, pixel_byte1, pixel_byte2,
                                                 // pixel_byte3
    input  logic                 s_axis_tlast,   // final_pixel

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // high_ticks, low_ticks, bit_value, zero pad
    output logic                 m_axis_tuser,   // pixel_done
    output logic                 m_axis_tlast,   // frame_end

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NS_W-1:0]      cfg_data
);

    cfg_ticks_t         cfg;

    logic               pix_valid_reg, pix_valid_next;
    logic [PIX_W-1:0]   pix_bits_reg,  pix_bits_next;
    logic [CNT_W-1:0]   pix_cnt_reg,   pix_cnt_next;
    logic               pix_final_reg, pix_final_next;

    logic               out_valid_reg, out_valid_next;
    logic [TICK_W-1:0]  out_high_reg,  out_high_next;
    logic [TICK_W-1:0]  out_low_reg,   out_low_next;
    logic               out_bit_reg,   out_bit_next;
    logic               out_done_reg,  out_done_next;
    logic               out_end_reg,   out_end_next;

    logic               in_take;
    logic               load_out;
    logic               pix_last;
    logic               cur_bit;
    logic               frame_last;

    assign cfg_ready = 1'b1;

    lspe_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign load_out      = pix_valid_reg && (!out_valid_reg || m_axis_tready);
    assign pix_last      = (pix_cnt_reg == '0);
    assign s_axis_tready = !pix_valid_reg || (load_out && pix_last);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cur_bit       = pix_bits_reg[PIX_W-1];
    assign frame_last    = pix_last && pix_final_reg;

    // Pixel register: bits kept in send order and shifted out from the top.
    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        pix_bits_next  = pix_bits_reg;
        pix_cnt_next   = pix_cnt_reg;
        pix_final_next = pix_final_reg;
        if (in_take)
        begin
            pix_valid_next = 1'b1;
            pix_bits_next  = {s_axis_tdata[15:8], s_axis_tdata[7:0],
                              s_axis_tdata[23:16], s_axis_tdata[31:24]};
            pix_cnt_next   = cfg.color_mode ? LAST_IDX_4 : LAST_IDX_3;
            pix_final_next = s_axis_tlast;
        end
        else if (load_out)
        begin
            pix_valid_next = !pix_last;
            pix_bits_next  = {pix_bits_reg[PIX_W-2:0], 1'b0};
            pix_cnt_next   = pix_cnt_reg - 1'b1;
        end
    end

    // Output register: one pulse item, held while the receiver stalls.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_high_next  = out_high_reg;
        out_low_next   = out_low_reg;
        out_bit_next   = out_bit_reg;
        out_done_next  = out_done_reg;
        out_end_next   = out_end_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_high_next  = cur_bit ? cfg.one_high : cfg.zero_high;
            if (frame_last)
            begin
                out_low_next = cfg.reset_low;
            end
            else
            begin
                out_low_next = cur_bit ? cfg.one_low : cfg.zero_low;
            end
            out_bit_next   = cur_bit;
            out_done_next  = pix_last;
            out_end_next   = frame_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_bits_reg  <= pix_bits_next;
        pix_cnt_reg   <= pix_cnt_next;
        pix_final_reg <= pix_final_next;
        out_high_reg  <= out_high_next;
        out_low_reg   <= out_low_next;
        out_bit_reg   <= out_bit_next;
        out_done_reg  <= out_done_next;
        out_end_reg   <= out_end_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_bit_reg, out_low_reg, out_high_reg};
    assign m_axis_tuser  = out_done_reg;
    assign m_axis_tlast  = out_end_reg;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// LED strip pulse encoder testbench
// Drives pixels on the input stream and timing registers on the configuration
// channel, and checks every pulse item against an encoder model or typed-in
// pulses. A short table of directed pixels runs first with the reset timings;
// after it come phases of random strips, each with its own register settings.
// ----------------------------------------------------------------------------
module testbench;
    import lspe_pkg::*;

    localparam int TICK_NS = 50;
    localparam int PHASES = 12;
    localparam int PIXELS_PER_PHASE = 35;
    localparam int DIR_ROWS = 17;

    // Indexes beyond the register map; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic              final_px;
    } pixel_t;

    typedef struct packed {
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic              bit_value;
        logic              pixel_done;
        logic              frame_end;
    } pulse_t;

    typedef struct packed {
        pixel_t            px;
        logic              typed;
        logic [TICK_W-1:0] exp_high;
        logic [TICK_W-1:0] exp_low;
        logic [TICK_W-1:0] exp_last_low;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [NS_W-1:0]      cfg_data;

    led_strip_pulse_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow copy of the timing registers, in nanoseconds as written.
    logic            shadow_mode;
    logic [NS_W-1:0] shadow_zero_high;
    logic [NS_W-1:0] shadow_zero_low;
    logic [NS_W-1:0] shadow_one_high;
    logic [NS_W-1:0] shadow_one_low;
    logic [NS_W-1:0] shadow_reset_low;

    pulse_t   pending_pulses[$];
    int       mismatch_count;
    int       burst_left;
    int       strip_left;
    dir_row_t dir_rows[DIR_ROWS];

    int rx_mode;
    int rx_left;
    int rx_stall;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [TICK_W-1:0] ns_to_tick_count(logic [NS_W-1:0] ns);
        return TICK_W'(ns / TICK_NS);
    endfunction

    // Expands one pixel into its pulse items, bytes in send order, MSB first.
    task automatic encode_pixel(input pixel_t px);
        logic [BYTE_W-1:0] send_order[4];
        int                nbytes;
        logic              one;
        logic              last;
        pulse_t            p;
        send_order[0] = px.b1;
        send_order[1] = px.b0;
        send_order[2] = px.b2;
        send_order[3] = px.b3;
        nbytes = shadow_mode ? 4 : 3;
        for (int i = 0; i < nbytes; i++)
        begin
            for (int k = BYTE_W - 1; k >= 0; k--)
            begin
                one = send_order[i][k];
                last = (i == nbytes - 1) && (k == 0);
                p.high_ticks = ns_to_tick_count(one ? shadow_one_high : shadow_zero_high);
                p.frame_end  = last && px.final_px;
                if (p.frame_end)
                    p.low_ticks = ns_to_tick_count(shadow_reset_low);
                else
                    p.low_ticks = ns_to_tick_count(one ? shadow_one_low : shadow_zero_low);
                p.bit_value  = one;
                p.pixel_done = last;
                pending_pulses.push_back(p);
            end
        end
    endtask

    // A row of equal sent bytes in three-byte mode: 24 pulses alike but the last low.
    task automatic push_typed(input dir_row_t row);
        pulse_t p;
        for (int n = 0; n < 3 * BYTE_W; n++)
        begin
            p.high_ticks = row.exp_high;
            p.low_ticks  = (n == 3 * BYTE_W - 1) ? row.exp_last_low : row.exp_low;
            p.bit_value  = row.px.b1[0];
            p.pixel_done = (n == 3 * BYTE_W - 1);
            p.frame_end  = (n == 3 * BYTE_W - 1) && row.px.final_px;
            pending_pulses.push_back(p);
        end
    endtask

    // Presents one pixel and returns in the time step of its transaction.
    task automatic send_pixel(input pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) < 7)
                gap = $urandom_range(0, 3);
            else
                gap = $urandom_range(4, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {px.b3, px.b2, px.b1, px.b0};
        s_axis_tlast  <= px.final_px;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_COLOR_MODE:   shadow_mode      = val[0];
            REG_ZERO_HIGH_NS: shadow_zero_high = val;
            REG_ZERO_LOW_NS:  shadow_zero_low  = val;
            REG_ONE_HIGH_NS:  shadow_one_high  = val;
            REG_ONE_LOW_NS:   shadow_one_low   = val;
            REG_RESET_LOW_NS: shadow_reset_low = val;
            default:          ;
        endcase
    endtask

    // Stops the input stream and lets the block drain completely.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_pulses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [NS_W-1:0] pick_ns();
        if ($urandom_range(0, 3) != 0)
            return NS_W'($urandom_range(0, 2000));
        return NS_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic configure_phase(input int ph);
        logic [NS_W-1:0] t[5];
        logic            mode;
        case (ph)
            1:
            begin
                mode = 1'b0;
                foreach (t[i]) t[i] = '0;
            end
            2:
            begin
                mode = 1'b1;
                foreach (t[i]) t[i] = 16'hFFFF;
            end
            3:
            begin
                mode = 1'b0;
                t = '{16'd49, 16'd50, 16'd99, 16'd100, 16'd65534};
            end
            4:
            begin
                mode = 1'b1;
                t = '{16'd65499, 16'd65500, 16'd1, 16'd65535, 16'd0};
            end
            default:
            begin
                mode = ($urandom_range(0, 1) == 1);
                foreach (t[i]) t[i] = pick_ns();
            end
        endcase
        // Only bit 0 of the mode write counts; the upper bits carry noise.
        write_reg(REG_COLOR_MODE, {(NS_W-1)'($urandom), mode});
        write_reg(REG_SPARE_6, NS_W'($urandom));
        write_reg(REG_ZERO_HIGH_NS, t[0]);
        write_reg(REG_ZERO_LOW_NS, t[1]);
        write_reg(REG_ONE_HIGH_NS, t[2]);
        write_reg(REG_ONE_LOW_NS, t[3]);
        write_reg(REG_RESET_LOW_NS, t[4]);
        write_reg(REG_SPARE_7, NS_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Receiver: switches at random between always ready, randomly ready and stall bursts.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_stall > 0)
                begin
                    rx_stall--;
                    m_axis_tready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    rx_stall = $urandom_range(1, 30);
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        pulse_t got;
        pulse_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.high_ticks = m_axis_tdata[TICK_W-1:0];
            got.low_ticks  = m_axis_tdata[2*TICK_W-1:TICK_W];
            got.bit_value  = m_axis_tdata[2*TICK_W];
            got.pixel_done = m_axis_tuser;
            got.frame_end  = m_axis_tlast;
            if (pending_pulses.size() == 0)
            begin
                $error("pulse transaction with nothing expected: tdata %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_pulses.pop_front();
                if (got.high_ticks !== want.high_ticks)
                begin
                    $error("high_ticks: expected %0d, got %0d", want.high_ticks, got.high_ticks);
                    mismatch_count++;
                end
                if (got.low_ticks !== want.low_ticks)
                begin
                    $error("low_ticks: expected %0d, got %0d", want.low_ticks, got.low_ticks);
                    mismatch_count++;
                end
                if (got.bit_value !== want.bit_value)
                begin
                    $error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
                    mismatch_count++;
                end
                if (got.pixel_done !== want.pixel_done)
                begin
                    $error("pixel_done: expected %0d, got %0d", want.pixel_done,
                           got.pixel_done);
                    mismatch_count++;
                end
                if (got.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        pixel_t px;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        mismatch_count = 0;
        burst_left = 0;
        strip_left = 0;
        rx_mode = 0;
        rx_left = 0;
        rx_stall = 0;
        shadow_mode      = 1'b0;
        shadow_zero_high = 16'd400;
        shadow_zero_low  = 16'd850;
        shadow_one_high  = 16'd800;
        shadow_one_low   = 16'd450;
        shadow_reset_low = 16'd50000;

        // Rows with all sent bytes equal carry their pulses typed in, using
        // the reset timings of 8/17 ticks for a zero and 16/9 for a one.
        dir_rows = '{
            '{'{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 11'd8,  11'd17, 11'd17},
            '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1, 11'd16, 11'd9,  11'd9},
            '{'{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1}, 1'b1, 11'd8,  11'd17, 11'd1000},
            '{'{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1}, 1'b1, 11'd16, 11'd9,  11'd1000},
            '{'{8'h80, 8'h01, 8'h55, 8'hAA, 1'b0}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'h01, 8'h80, 8'hAA, 8'h55, 1'b1}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'h7F, 8'hFE, 8'h0F, 8'hF0, 1'b0}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'h12, 8'h34, 8'h56, 8'h78, 1'b0}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'h01, 8'h02, 8'h04, 8'h08, 1'b0}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'h10, 8'h20, 8'h40, 8'h80, 1'b0}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'hFE, 8'hFD, 8'hFB, 8'hF7, 1'b1}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'hEF, 8'hDF, 8'hBF, 8'h7F, 1'b0}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'h00, 8'h00, 8'h01, 8'h00, 1'b1}, 1'b0, 11'd0, 11'd0, 11'd0},
            '{'{8'hFF, 8'hFF, 8'hFE, 8'hFF, 1'b1}, 1'b0, 11'd0, 11'd0, 11'd0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_pixel(dir_rows[r].px);
            if (dir_rows[r].typed)
                push_typed(dir_rows[r]);
            else
                encode_pixel(dir_rows[r].px);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            configure_phase(ph);
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
            begin
                // Pixels come in strips that end on a final pixel; a few
                // final flags are flipped to break the strip shape.
                if (strip_left == 0)
                    strip_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
                px.b0 = pick_byte();
                px.b1 = pick_byte();
                px.b2 = pick_byte();
                px.b3 = pick_byte();
                px.final_px = (strip_left == 1);
                if ($urandom_range(0, 15) == 0)
                    px.final_px = ~px.final_px;
                strip_left--;
                send_pixel(px);
                encode_pixel(px);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_pulses.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
design/lspe_pkg.sv
design/lspe_cfg_regs.sv
design/led_strip_pulse_encoder.sv
bench/testbench.sv
